### src/iprl_pkg.sv
// Shared types and constants for the IPv4 route lookup block.
// Stream word layouts, table entry record and controller/datapath command bundle.
// No dependencies.
package iprl_pkg;

    localparam int IDX_W   = 4;
    localparam int ADDR_W  = 32;
    localparam int IFACE_W = 2;
    localparam int N_IFACE = 4;
    localparam int CFG_IDX_W = 8;

    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_WRITE  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_IFACE_ADDR_0 = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IFACE_ADDR_1 = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IFACE_ADDR_2 = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IFACE_ADDR_3 = 8'd3;

    // input word, first field in the highest bits
    typedef struct packed {
        logic               pad;
        logic [ADDR_W-1:0]  src_addr;
        logic [ADDR_W-1:0]  dst_addr;
        logic [IFACE_W-1:0] entry_iface;
        logic [ADDR_W-1:0]  entry_gateway;
        logic [ADDR_W-1:0]  entry_mask;
        logic [ADDR_W-1:0]  entry_dest;
        logic               entry_valid;
        logic [IDX_W-1:0]   entry_index;
    } in_word_t;

    // result word, first field in the highest bits
    typedef struct packed {
        logic [4:0]         pad;
        logic               src_filled;
        logic [ADDR_W-1:0]  src_out;
        logic [ADDR_W-1:0]  next_hop;
        logic [IFACE_W-1:0] out_iface;
    } out_word_t;

    localparam int IN_W  = $bits(in_word_t);
    localparam int OUT_W = $bits(out_word_t);

    typedef struct packed {
        logic [ADDR_W-1:0]  dest;
        logic [ADDR_W-1:0]  mask;
        logic [ADDR_W-1:0]  gateway;
        logic [IFACE_W-1:0] iface;
    } route_entry_t;

    // controller to datapath
    typedef struct packed {
        logic             accept;   // input word taken this cycle
        logic             rd_en;    // read table entry at rd_addr
        logic [IDX_W-1:0] rd_addr;
        logic             emit;     // load result register
    } dp_cmd_t;

endpackage

### src/iprl_ctrl.sv
// Lookup sequencer: accepts words, steps the table scan, hands results to the
// output register. Depends on iprl_pkg.
module iprl_ctrl import iprl_pkg::*; #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_tvalid,
    output logic    s_tready,
    input  logic    s_tuser,
    output logic    m_tvalid,
    input  logic    m_tready,
    output dp_cmd_t cmd
);

    localparam int ENTRIES = (TABLE_DEPTH < (1 << IDX_W)) ? TABLE_DEPTH : (1 << IDX_W);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic             accept;
    logic             out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !m_tready;
        cmd            = '0;
        cmd.accept     = accept;
        cmd.rd_addr    = cnt_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cnt_next   = '0;
                    state_next = (s_tuser == CMD_WRITE) ? ST_EMIT : ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.rd_en = 1'b1;
                if (cnt_reg == LAST_IDX) begin
                    state_next = ST_DRAIN;
                end else begin
                    cnt_next = cnt_reg + IDX_W'(1);
                end
            end
            ST_DRAIN: begin
                // last entry is compared on this edge
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### src/iprl_datapath.sv
// Route table memory, valid bits, best-match and default-route tracking,
// interface address registers and result register. Depends on iprl_pkg.
module iprl_datapath import iprl_pkg::*; #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  dp_cmd_t              cmd,
    input  logic                 in_user,
    input  in_word_t             in_word,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [ADDR_W-1:0]    cfg_data,
    output logic                 out_found,
    output out_word_t            out_word
);

    localparam int ENTRIES = (TABLE_DEPTH < (1 << IDX_W)) ? TABLE_DEPTH : (1 << IDX_W);
    localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int MEM_D   = 1 << AW;

    route_entry_t       table_mem [MEM_D];
    logic [MEM_D-1:0]   valid_reg;

    route_entry_t       rd_data_reg;
    logic               rd_vld_reg;
    logic               cmp_en_reg;

    logic               is_write_reg;
    logic [ADDR_W-1:0]  dst_reg;
    logic [ADDR_W-1:0]  src_reg;

    logic               best_found_reg;
    logic [ADDR_W-1:0]  best_mask_reg;
    logic [ADDR_W-1:0]  best_gw_reg;
    logic [IFACE_W-1:0] best_if_reg;
    logic               dflt_found_reg;
    logic [ADDR_W-1:0]  dflt_gw_reg;
    logic [IFACE_W-1:0] dflt_if_reg;

    logic [ADDR_W-1:0]  iface_addr_reg [N_IFACE];

    logic               found_reg;
    out_word_t          out_word_reg;

    logic               idx_ok;
    logic               wr_en;
    route_entry_t       wr_entry;
    logic               hit;
    logic               dflt_hit;

    logic               res_found;
    logic [ADDR_W-1:0]  sel_gw;
    logic [IFACE_W-1:0] sel_if;
    out_word_t          res_word;

    assign idx_ok = (ENTRIES >= (1 << IDX_W)) ||
                    (in_word.entry_index < IDX_W'(ENTRIES));
    assign wr_en  = cmd.accept && (in_user == CMD_WRITE) && idx_ok;

    assign wr_entry.dest    = in_word.entry_dest;
    assign wr_entry.mask    = in_word.entry_mask;
    assign wr_entry.gateway = in_word.entry_gateway;
    assign wr_entry.iface   = in_word.entry_iface;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            table_mem[in_word.entry_index[AW-1:0]] <= wr_entry;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= table_mem[cmd.rd_addr[AW-1:0]];
            rd_vld_reg  <= valid_reg[cmd.rd_addr[AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            cmp_en_reg <= 1'b0;
        end else begin
            cmp_en_reg <= cmd.rd_en;
            if (wr_en) begin
                valid_reg[in_word.entry_index[AW-1:0]] <= in_word.entry_valid;
            end
        end
    end

    // strictly larger mask wins, so a zero mask only ever serves as default
    assign hit = rd_vld_reg &&
                 ((dst_reg & rd_data_reg.mask) == (rd_data_reg.dest & rd_data_reg.mask)) &&
                 (rd_data_reg.mask > best_mask_reg);
    assign dflt_hit = rd_vld_reg && !dflt_found_reg &&
                      (rd_data_reg.dest == '0) && (rd_data_reg.mask == '0);

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            is_write_reg   <= (in_user == CMD_WRITE);
            dst_reg        <= in_word.dst_addr;
            src_reg        <= in_word.src_addr;
            best_found_reg <= 1'b0;
            best_mask_reg  <= '0;
            dflt_found_reg <= 1'b0;
        end else if (cmp_en_reg) begin
            if (hit) begin
                best_found_reg <= 1'b1;
                best_mask_reg  <= rd_data_reg.mask;
                best_gw_reg    <= rd_data_reg.gateway;
                best_if_reg    <= rd_data_reg.iface;
            end
            if (dflt_hit) begin
                dflt_found_reg <= 1'b1;
                dflt_gw_reg    <= rd_data_reg.gateway;
                dflt_if_reg    <= rd_data_reg.iface;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < N_IFACE; i++) begin
                iface_addr_reg[i] <= '0;
            end
        end else if (cfg_valid) begin
            unique case (cfg_addr)
                REG_IFACE_ADDR_0: iface_addr_reg[0] <= cfg_data;
                REG_IFACE_ADDR_1: iface_addr_reg[1] <= cfg_data;
                REG_IFACE_ADDR_2: iface_addr_reg[2] <= cfg_data;
                REG_IFACE_ADDR_3: iface_addr_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    assign sel_gw    = best_found_reg ? best_gw_reg : dflt_gw_reg;
    assign sel_if    = best_found_reg ? best_if_reg : dflt_if_reg;

    always_comb begin
        res_word  = '0;
        res_found = 1'b0;
        if (!is_write_reg) begin
            res_word.src_out = src_reg;
            if (best_found_reg || dflt_found_reg) begin
                res_found          = 1'b1;
                res_word.out_iface = sel_if;
                res_word.next_hop  = (sel_gw != '0) ? sel_gw : dst_reg;
                if (src_reg == '0) begin
                    res_word.src_out    = iface_addr_reg[sel_if];
                    res_word.src_filled = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            found_reg    <= res_found;
            out_word_reg <= res_word;
        end
    end

    assign out_found = found_reg;
    assign out_word  = out_word_reg;

endmodule

### src/ipv4_route_lookup_top.sv
// Lookup: the word is accepted, min(TABLE_DEPTH,16) entries are scanned (one table read per
// cycle), then a drain and a result state follow before the next word is taken.
// A table write goes from accept straight to the result state. The next word is taken while a result waits.
// Synchronous active-low reset clears valid bits, interface addresses and
// control; table contents stay undefined until written.
// Top level of the IPv4 route lookup; instantiates iprl_ctrl and iprl_datapath.
module ipv4_route_lookup_top import iprl_pkg::*; #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // tdata: entry_index, entry_valid, entry_dest, entry_mask, entry_gateway,
    //        entry_iface, dst_addr, src_addr, zero pad
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [IN_W-1:0]      s_tdata,
    input  logic                 s_tuser,    // command
    // tdata: out_iface, next_hop, src_out, src_filled, zero pad
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [OUT_W-1:0]     m_tdata,
    output logic                 m_tuser,    // route_found
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [ADDR_W-1:0]    cfg_data
);

    dp_cmd_t   cmd;
    out_word_t out_word;

    assign cfg_ready = 1'b1;

    iprl_ctrl #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    iprl_datapath #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .in_user   (s_tuser),
        .in_word   (in_word_t'(s_tdata)),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .out_found (m_tuser),
        .out_word  (out_word)
    );

    assign m_tdata = OUT_W'(out_word);

    // no route, or a write: interface, next hop and fill flag are zero
    a_no_route_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (out_word.out_iface == '0 && out_word.next_hop == '0 &&
                                    !out_word.src_filled))
        else $error("result without route carries route fields");

    // source is only filled in when a route was chosen
    a_fill_needs_route: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_word.src_filled) |-> m_tuser)
        else $error("source filled without a route");

    // a lookup holds off the input side while the table is scanned
    a_lookup_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == CMD_LOOKUP) |=> !s_tready)
        else $error("input accepted during table scan");

    // a filled source is the chosen interface's address
    a_fill_matches_iface: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_word.src_filled && $stable(cfg_data) && !cfg_valid) |->
            (out_word.src_out == u_datapath.iface_addr_reg[out_word.out_iface]))
        else $error("filled source differs from interface address");

endmodule
